// ===== src/srk_pkg.sv =====
// ----------------------------------------------------------------------------
// srk_pkg
// Shared types and constants for the symmetric rank-one update core.
// ----------------------------------------------------------------------------
package srk_pkg;

  localparam int Q_W       = 32;  // Q16.16 data word
  localparam int FRAC_W    = 16;  // fraction bits
  localparam int IDX_W     = 6;   // width of the item index fields
  localparam int LEN_W     = 7;   // width of the vector length register
  localparam int CFG_IDX_W = 3;   // configuration register index width

  localparam logic [Q_W-1:0] ALPHA_RESET = 32'h0001_0000;  // 1.0

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_LOWER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_MAJOR     = 3'd3;

  // Request commands.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_MUL_P,
    ST_FIN
  } srk_state_t;

endpackage

// ===== src/srk_vstore.sv =====
// ----------------------------------------------------------------------------
// srk_vstore
// Vector element store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module srk_vstore #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [srk_pkg::Q_W-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr_a,
  input  logic [AW-1:0]          rd_addr_b,
  output logic [srk_pkg::Q_W-1:0] rd_data_a,
  output logic [srk_pkg::Q_W-1:0] rd_data_b
);
  import srk_pkg::*;

  logic [Q_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== src/srk_qmul.sv =====
// ----------------------------------------------------------------------------
// srk_qmul
// Shared Q16.16 multiplier: floor(a*b / 2^16), saturated, into a register.
// ----------------------------------------------------------------------------
module srk_qmul (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [srk_pkg::Q_W-1:0] op_a,
  input  logic signed [srk_pkg::Q_W-1:0] op_b,
  output logic signed [srk_pkg::Q_W-1:0] q_r
);
  import srk_pkg::*;

  logic signed [2*Q_W-1:0] prod;
  logic signed [Q_W-1:0]   q_nxt;
  logic                    ovf;

  assign prod = op_a * op_b;

  // The shifted product fits when all bits above the kept word agree
  // with its sign bit; an arithmetic shift already rounds toward minus infinity.
  assign ovf = !((&prod[2*Q_W-1:Q_W+FRAC_W-1]) || !(|prod[2*Q_W-1:Q_W+FRAC_W-1]));

  always_comb begin
    if (!ovf) begin
      q_nxt = prod[Q_W+FRAC_W-1:FRAC_W];
    end else if (prod[2*Q_W-1]) begin
      q_nxt = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      q_nxt = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== src/symmetric_rank1_update_core.sv =====
// ----------------------------------------------------------------------------
// symmetric_rank1_update_core
// Streams A := A + alpha * x * x^T over one triangle in signed Q16.16.
// ----------------------------------------------------------------------------
// Load requests write vector elements into an internal store and do not
// stall the block; a load whose index is at or above MAX_DIM is dropped. Update
// requests carry one matrix element with its storage-order outer and inner
// index and return exactly one result. An element inside the configured
// triangle comes back as value + alpha * x[outer] * x[inner], with both
// products floored to Q16.16 and every step saturated to 32 bits. An element
// outside the triangle, or with an index at or above the vector length, comes
// back unchanged. An in-triangle update steps through accept, alpha times
// x[outer], x[inner] times that term and final add, because one multiplier
// is shared by both products; any other update goes from accept straight to
// the final step, which waits while a stalled result holds the output
// register. The block accepts one request at a time, but a finished result
// may wait in the output register while the next request is taken. The
// vector store has no reset: reading an unloaded element gives an undefined value.
// ----------------------------------------------------------------------------
module symmetric_rank1_update_core #(
  parameter int MAX_DIM = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port.
  input  logic                             cfg_wr_en,
  input  logic [srk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srk_pkg::Q_W-1:0]          cfg_wr_data,
  // Request channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [srk_pkg::IDX_W-1:0]        in_outer_index,
  input  logic [srk_pkg::IDX_W-1:0]        in_inner_index,
  input  logic signed [srk_pkg::Q_W-1:0]   in_value_in,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [srk_pkg::Q_W-1:0]   out_value_out,
  output logic                             out_was_updated,
  output logic                             out_index_error
);
  import srk_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // Configuration registers.
  logic [LEN_W-1:0]     vector_length_r;
  logic signed [Q_W-1:0] alpha_r;
  logic                 use_lower_r;
  logic                 row_major_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_length_r <= '0;
      alpha_r         <= ALPHA_RESET;
      use_lower_r     <= 1'b0;
      row_major_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VECTOR_LENGTH: vector_length_r <= cfg_wr_data[LEN_W-1:0];
        CFG_ALPHA_SCALE:   alpha_r         <= cfg_wr_data;
        CFG_USE_LOWER:     use_lower_r     <= cfg_wr_data[0];
        CFG_ROW_MAJOR:     row_major_r     <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // Request decode at the accept edge.
  srk_state_t state_r, state_nxt;
  logic       accept;
  logic       is_update;
  logic [LEN_W-1:0] n_eff;
  logic       idx_err;
  logic       in_tri;
  logic       store_wr;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_update = (in_command == CMD_UPDATE);

  // The dimension in use is the vector length, capped at the store depth.
  assign n_eff = (32'(vector_length_r) < MAX_DIM) ? vector_length_r : LEN_W'(MAX_DIM);

  assign idx_err = ({1'b0, in_outer_index} >= n_eff) || ({1'b0, in_inner_index} >= n_eff);

  // Upper/lower and the storage order together pick which side of the
  // diagonal is updated.
  assign in_tri = (use_lower_r ^ row_major_r) ? (in_inner_index >= in_outer_index)
                                              : (in_inner_index <= in_outer_index);

  assign store_wr = accept && !is_update && (32'(in_outer_index) < MAX_DIM);

  // Per-request payload held while the request is worked on.
  logic signed [Q_W-1:0] value_r;
  logic                  upd_r;
  logic                  err_r;

  always_ff @(posedge clk) begin
    if (accept && is_update) begin
      value_r <= in_value_in;
      upd_r   <= !idx_err && in_tri;
      err_r   <= idx_err;
    end
  end

  // Vector store.
  logic [Q_W-1:0] x_outer, x_inner;

  srk_vstore #(
    .DEPTH (MAX_DIM),
    .AW    (AW)
  ) u_vstore (
    .clk       (clk),
    .wr_en     (store_wr),
    .wr_addr   (AW'(in_outer_index)),
    .wr_data   (in_value_in),
    .rd_en     (accept && is_update),
    .rd_addr_a (AW'(in_outer_index)),
    .rd_addr_b (AW'(in_inner_index)),
    .rd_data_a (x_outer),
    .rd_data_b (x_inner)
  );

  // Shared multiplier: first alpha * x[outer], then x[inner] times that.
  logic                  mul_en;
  logic signed [Q_W-1:0] mul_a, mul_b;
  logic signed [Q_W-1:0] mul_q;

  srk_qmul u_qmul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .q_r  (mul_q)
  );

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic signed [Q_W-1:0] out_value_r;
  logic                  out_upd_r;
  logic                  out_err_r;
  logic                  out_free;
  logic                  out_load;
  logic signed [Q_W:0]   sum;
  logic signed [Q_W-1:0] sum_sat;

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_update) begin
          state_nxt = (!idx_err && in_tri) ? ST_MUL_T : ST_FIN;
        end
      end
      ST_MUL_T: state_nxt = ST_MUL_P;
      ST_MUL_P: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    mul_en   = 1'b0;
    mul_a    = alpha_r;
    mul_b    = x_outer;
    out_load = 1'b0;
    case (state_r)
      ST_MUL_T: begin
        mul_en = 1'b1;
      end
      ST_MUL_P: begin
        mul_en = 1'b1;
        mul_a  = x_inner;
        mul_b  = mul_q;
      end
      ST_FIN: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Final saturating add of the update term.
  assign sum = {value_r[Q_W-1], value_r} + {mul_q[Q_W-1], mul_q};

  always_comb begin
    if (sum[Q_W] == sum[Q_W-1]) begin
      sum_sat = sum[Q_W-1:0];
    end else if (sum[Q_W]) begin
      sum_sat = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= upd_r ? sum_sat : value_r;
      out_upd_r   <= upd_r;
      out_err_r   <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_out   = out_value_r;
  assign out_was_updated = out_upd_r;
  assign out_index_error = out_err_r;

endmodule
